/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/rcdm_pkg.sv */
// ---------------------------------------------------------------------------
// rcdm_pkg
// Types and constants of the remote command drive mixer.
// ---------------------------------------------------------------------------
package rcdm_pkg;

  // Remote command codes
  typedef enum logic [2:0] {
    CMD_STOP       = 3'd0,
    CMD_FORWARD    = 3'd1,
    CMD_REVERSE    = 3'd2,
    CMD_LEFT       = 3'd3,
    CMD_RIGHT      = 3'd4,
    CMD_SPIN_LEFT  = 3'd5,
    CMD_SPIN_RIGHT = 3'd6,
    CMD_OTHER      = 3'd7
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE  = 3'd4;

  // Widths
  localparam int SPD_W   = 8;   // register and duty width
  localparam int WHEEL_W = 9;   // stored wheel speed width
  localparam int IN_W    = 8;   // input tdata width
  localparam int RES_W   = 19;  // packed result fields
  localparam int OUT_W   = 24;  // output tdata width

  // Reset values of the registers
  localparam logic [SPD_W-1:0] NOMINAL_RST = 8'd150;
  localparam logic [SPD_W-1:0] STEP_RST    = 8'd16;
  localparam logic [SPD_W-1:0] MIN_RST     = 8'd60;
  localparam logic [SPD_W-1:0] MAX_RST     = 8'd255;
  localparam logic [SPD_W-1:0] ROTATE_RST  = 8'd120;

  // Inner wheel slows by step >> TURN_SHIFT on turns
  localparam int TURN_SHIFT = 2;

  typedef struct packed {
    logic [WHEEL_W-1:0] outer;
    logic [WHEEL_W-1:0] inner;
  } wheel_pair_t;

endpackage

/* rtl/core/remote_command_drive_mixer.sv */
// ---------------------------------------------------------------------------
// remote_command_drive_mixer
// Two-wheel speed mixer driven by remote-control commands.
// ---------------------------------------------------------------------------
// One command item in gives one result item out. An accepted item sits in an
// input register, the speed update (clamp, add, turn floors, power-off) runs
// in one pass of add-and-compare logic, and the result lands in an output
// register; a new item is taken every cycle while the output side keeps up.
// The wheel speeds and the last direction command live in registers that the
// same pass updates, so consecutive items see each other's effect with no
// gap. Configuration registers may only be written while no item is in flight.
`include "assert_macros.svh"

module remote_command_drive_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream: [2:0] command, [3] power_on, [7:4] zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rcdm_pkg::IN_W-1:0]         in_tdata,
  // Result stream: [7:0] left_pwm, [15:8] right_pwm, [16] left_forward,
  // [17] right_forward, [18] pause_first, [23:19] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rcdm_pkg::OUT_W-1:0]        out_tdata,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [rcdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcdm_pkg::SPD_W-1:0]        cfg_wdata
);
  import rcdm_pkg::*;

  // Configuration registers
  logic [SPD_W-1:0] nominal_r, step_r, min_r, max_r, rotate_r;

  // Pipeline registers
  logic             in_v_r;
  cmd_t             cmd_r;
  logic             power_r;
  logic             out_v_r;
  logic [RES_W-1:0] res_r;

  // Drive state
  logic [WHEEL_W-1:0] left_r, right_r;
  cmd_t               last_dir_r;

  // Next-state values
  logic [WHEEL_W-1:0] left_nxt, right_nxt;
  cmd_t               last_dir_nxt;
  logic [RES_W-1:0]   res_nxt;

  logic               advance;
  logic [WHEEL_W-1:0] max_w, left_base, right_base;
  logic [WHEEL_W-1:0] add_w, restart_w;
  logic               spin, lf, rf, pause;
  logic [SPD_W-1:0]   left_duty, right_duty;
  wheel_pair_t        turn_res;

  // Outer wheel speeds up, inner wheel slows down, both with floors
  function automatic wheel_pair_t turn_f(input logic [WHEEL_W-1:0] outer,
                                         input logic [WHEEL_W-1:0] inner,
                                         input logic [SPD_W-1:0]   stp,
                                         input logic [SPD_W-1:0]   mn);
    wheel_pair_t        r;
    logic [WHEEL_W-1:0] cut;
    logic [WHEEL_W-1:0] mn_w;
    logic [WHEEL_W-1:0] stp_w;
    cut   = {{(WHEEL_W-SPD_W){1'b0}}, stp} >> TURN_SHIFT;
    mn_w  = {{(WHEEL_W-SPD_W){1'b0}}, mn};
    stp_w = {{(WHEEL_W-SPD_W){1'b0}}, stp};
    r.outer = outer + stp_w;
    if (r.outer < mn_w) begin
      r.outer = mn_w + stp_w;
    end
    if (inner < mn_w + cut) begin
      r.inner = mn_w;
    end else begin
      r.inner = inner - cut;
    end
    return r;
  endfunction

  // Duty: zero stays zero, else clamp to max and raise to min
  function automatic logic [SPD_W-1:0] duty_f(input logic [WHEEL_W-1:0] s,
                                              input logic [SPD_W-1:0]   mx,
                                              input logic [SPD_W-1:0]   mn);
    logic [SPD_W-1:0] c;
    c = (s < {1'b0, mx}) ? s[SPD_W-1:0] : mx;
    if (c == '0) begin
      return '0;
    end
    return (c > mn) ? c : mn;
  endfunction

  // Move an item from the input register to the output register
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= NOMINAL_RST;
      step_r    <= STEP_RST;
      min_r     <= MIN_RST;
      max_r     <= MAX_RST;
      rotate_r  <= ROTATE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NOMINAL: nominal_r <= cfg_wdata;
        REG_STEP:    step_r    <= cfg_wdata;
        REG_MIN:     min_r     <= cfg_wdata;
        REG_MAX:     max_r     <= cfg_wdata;
        REG_ROTATE:  rotate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= cmd_t'(in_tdata[2:0]);
      power_r <= in_tdata[3];
    end
  end

  // Speed update for the item in the input register
  always_comb begin
    max_w      = {1'b0, max_r};
    left_base  = (left_r < max_w) ? left_r : max_w;
    right_base = (right_r < max_w) ? right_r : max_w;
    if (last_dir_r == CMD_STOP) begin
      left_base  = {1'b0, nominal_r};
      right_base = {1'b0, nominal_r};
    end

    spin      = (cmd_r == CMD_SPIN_LEFT) || (cmd_r == CMD_SPIN_RIGHT);
    add_w     = {1'b0, (spin ? rotate_r : step_r)};
    restart_w = {1'b0, (spin ? rotate_r : nominal_r)};
    turn_res  = '0;

    left_nxt     = left_base;
    right_nxt    = right_base;
    last_dir_nxt = last_dir_r;
    lf           = 1'b1;
    rf           = 1'b1;
    pause        = 1'b0;

    case (cmd_r)
      CMD_FORWARD, CMD_REVERSE, CMD_SPIN_LEFT, CMD_SPIN_RIGHT: begin
        left_nxt  = left_base + add_w;
        right_nxt = right_base + add_w;
        if (last_dir_r != cmd_r) begin
          pause     = 1'b1;
          left_nxt  = restart_w;
          right_nxt = restart_w;
        end
        last_dir_nxt = cmd_r;
        lf = !((cmd_r == CMD_REVERSE) || (cmd_r == CMD_SPIN_LEFT));
        rf = !((cmd_r == CMD_REVERSE) || (cmd_r == CMD_SPIN_RIGHT));
      end
      CMD_LEFT: begin
        turn_res  = turn_f(right_base, left_base, step_r, min_r);
        right_nxt = turn_res.outer;
        left_nxt  = turn_res.inner;
      end
      CMD_RIGHT: begin
        turn_res  = turn_f(left_base, right_base, step_r, min_r);
        left_nxt  = turn_res.outer;
        right_nxt = turn_res.inner;
      end
      default: begin
        left_nxt  = '0;
        right_nxt = '0;
      end
    endcase

    // Drop both wheels when power is off
    if (!power_r) begin
      left_nxt  = '0;
      right_nxt = '0;
    end

    left_duty  = duty_f(left_nxt, max_r, min_r);
    right_duty = duty_f(right_nxt, max_r, min_r);
    res_nxt    = {pause, rf, lf, right_duty, left_duty};
  end

  // Drive state advances with each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      right_r    <= '0;
      last_dir_r <= CMD_STOP;
    end else if (advance) begin
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      last_dir_r <= last_dir_nxt;
    end
  end

  // Output register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W-RES_W){1'b0}}, res_r};

  // Duty is zero or at least the minimum
  `ASSERT_CLK(a_duty_floor, clk, rst_n,
    advance |-> ((left_duty == '0 || left_duty >= min_r) &&
                 (right_duty == '0 || right_duty >= min_r)),
    "nonzero duty below minimum")
  // Power off leaves both wheels stopped
  `ASSERT_CLK(a_power_off, clk, rst_n,
    (advance && !power_r) |=> (left_r == '0 && right_r == '0),
    "wheel speed left nonzero with power off")
  // A direction command becomes the history
  `ASSERT_CLK(a_history, clk, rst_n,
    (advance && (cmd_r == CMD_FORWARD || cmd_r == CMD_REVERSE ||
                 cmd_r == CMD_SPIN_LEFT || cmd_r == CMD_SPIN_RIGHT))
      |=> (last_dir_r == $past(cmd_r)),
    "direction history not updated")
  // History holds only direction codes
  `ASSERT_NEVER(a_history_code, clk, rst_n,
    (last_dir_r == CMD_LEFT || last_dir_r == CMD_RIGHT || last_dir_r == CMD_OTHER),
    "history holds a non-direction code")
  // A pending result is not lost while stalled
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    (out_v_r && !out_tready) |=> (out_v_r && $stable(res_r)),
    "pending result dropped")

endmodule
